FILE: rtl/accel_motion_detector_defines.svh
// Assertion macros shared by the motion detector RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ACCEL_MOTION_DETECTOR_DEFINES_SVH
`define ACCEL_MOTION_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/amd_pkg.sv
package amd_pkg;

	localparam int FILTER_DEPTH = 8;
	localparam int SLOT_W       = $clog2(FILTER_DEPTH);
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = SAMPLE_W + SLOT_W;
	localparam int LANE_ERR_W   = SAMPLE_W;
	localparam int MERR_W       = 18;
	localparam int TICK_W       = 32;
	localparam int THR_W        = 12;
	localparam int CFG_W        = 4;

	localparam logic [THR_W-1:0] BASE_LEVEL = THR_W'(1500);
	localparam logic [THR_W-1:0] STEP_SIZE  = THR_W'(200);
	localparam logic [CFG_W-1:0] MAX_STEP   = CFG_W'(9);
	localparam logic [THR_W-1:0] TOP_LEVEL  = BASE_LEVEL + THR_W'(9) * STEP_SIZE;

	localparam logic [1:0] TILT_LEFT   = 2'd0;
	localparam logic [1:0] TILT_FLAT   = 2'd2;
	localparam logic [1:0] FOLLOW_MODE = 2'd2;

	localparam logic REG_SENS   = 1'b0;
	localparam logic REG_ORIENT = 1'b1;

	// Shared pipeline control from the top level to every axis lane.
	typedef struct packed {
		logic              ld1;
		logic              ld2;
		logic              primed;
		logic [SLOT_W-1:0] slot;
	} lane_ctrl_t;

endpackage

FILE: rtl/amd_lane.sv
module amd_lane (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  amd_pkg::lane_ctrl_t                       ctrl,
	input  logic signed [amd_pkg::SAMPLE_W-1:0]       sample,
	output logic        [amd_pkg::LANE_ERR_W-1:0]     err_s2
);
	import amd_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_DIV = SUM_W'(FILTER_DEPTH);

	logic signed [SAMPLE_W-1:0] ring_q [FILTER_DEPTH];
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_next;
	logic signed [SUM_W-1:0]    sample_ext;
	logic signed [SUM_W-1:0]    old_ext;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [SUM_W-1:0]    sum_s1;
	logic signed [SUM_W-1:0]    quot;
	logic signed [SAMPLE_W:0]   diff;
	logic        [SAMPLE_W:0]   diff_abs;

	always_comb begin
		sample_ext = SUM_W'(sample);
		old_ext    = SUM_W'(ring_q[ctrl.slot]);
		if (ctrl.primed) begin
			sum_next = sum_q - old_ext + sample_ext;
		end else begin
			sum_next = sample_ext * SUM_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.ld1) begin
			sum_q <= sum_next;
		end
	end

	// The first sample after reset fills every slot of the ring.
	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			for (int i = 0; i < FILTER_DEPTH; i++) begin
				if (!ctrl.primed || ctrl.slot == SLOT_W'(i)) begin
					ring_q[i] <= sample;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			sample_s1 <= sample;
			sum_s1    <= sum_next;
		end
	end

	// Signed division truncates toward zero, which the average needs.
	always_comb begin
		quot     = sum_s1 / SUM_DIV;
		diff     = quot[SAMPLE_W:0] - {sample_s1[SAMPLE_W-1], sample_s1};
		diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld2) begin
			err_s2 <= diff_abs[LANE_ERR_W-1:0];
		end
	end

endmodule

FILE: rtl/amd_merge.sv
`include "accel_motion_detector_defines.svh"

module amd_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  ld3,
	input  logic                                  out_ready,
	input  logic [amd_pkg::LANE_ERR_W-1:0]        err_x,
	input  logic [amd_pkg::LANE_ERR_W-1:0]        err_y,
	input  logic [amd_pkg::LANE_ERR_W-1:0]        err_z,
	input  logic [amd_pkg::CFG_W-1:0]             sensitivity,
	input  logic [amd_pkg::TICK_W-1:0]            tick_s2,
	input  logic                                  flip_s2,
	output logic                                  out_valid,
	output logic                                  moved,
	output logic [amd_pkg::MERR_W-1:0]            motion_error,
	output logic [amd_pkg::TICK_W-1:0]            last_move_tick,
	output logic                                  flip_display
);
	import amd_pkg::*;

	logic [MERR_W-1:0] total;
	logic [CFG_W-1:0]  step;
	logic [THR_W-1:0]  threshold;
	logic              over;

	always_comb begin
		total     = MERR_W'(err_x) + MERR_W'(err_y) + MERR_W'(err_z);
		step      = (sensitivity > MAX_STEP) ? MAX_STEP : sensitivity;
		threshold = TOP_LEVEL - THR_W'(step) * STEP_SIZE;
		over      = total > MERR_W'(threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			last_move_tick <= '0;
		end else begin
			if (ld3) begin
				out_valid <= 1'b1;
				if (over) begin
					last_move_tick <= tick_s2;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			moved        <= over;
			motion_error <= total;
			flip_display <= flip_s2;
		end
	end

	// The lowest threshold is the base level, so a movement always exceeds it.
	`AMD_ASSERT_NOW(a_moved_above_base, out_valid && moved,
		motion_error > MERR_W'(BASE_LEVEL), "movement flagged below the base level")

endmodule

FILE: rtl/accel_motion_detector.sv
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_ready    accel_x, accel_y, accel_z, tilt_code, tick_now
// out       result     out_valid / out_ready  moved, motion_error, last_move_tick, flip_display
// cfg       write      cfg_we                 cfg_idx, cfg_data
//
// One request per cycle is accepted unless a stalled output has backed up the pipeline.
// The running sums are updated in the accept cycle, so that adder sets the rate.
// The three axis lanes run in parallel and a merge stage adds their errors.
// Reset clears the valid bits, sums, write slot, latched tick and display state.
// A stalled result holds the output; requests still enter while a stage is empty.
`include "accel_motion_detector_defines.svh"

module accel_motion_detector (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_idx,
	input  logic [amd_pkg::CFG_W-1:0]              cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [amd_pkg::SAMPLE_W-1:0]    accel_x,
	input  logic signed [amd_pkg::SAMPLE_W-1:0]    accel_y,
	input  logic signed [amd_pkg::SAMPLE_W-1:0]    accel_z,
	input  logic [1:0]                             tilt_code,
	input  logic [amd_pkg::TICK_W-1:0]             tick_now,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   moved,
	output logic [amd_pkg::MERR_W-1:0]             motion_error,
	output logic [amd_pkg::TICK_W-1:0]             last_move_tick,
	output logic                                   flip_display
);
	import amd_pkg::*;

	logic [CFG_W-1:0]      sens_q;
	logic [1:0]            mode_q;
	logic                  primed_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  flip_q;
	logic                  flip_next;
	logic                  v1_q;
	logic                  v2_q;
	logic                  ld1, ld2, ld3;
	logic [TICK_W-1:0]     tick_s1, tick_s2;
	logic                  flip_s1, flip_s2;
	lane_ctrl_t            ctrl;
	logic [LANE_ERR_W-1:0] err_x, err_y, err_z;

	// Each stage loads when it is empty or its contents move on this cycle.
	always_comb begin
		ld3      = v2_q && (!out_valid || out_ready);
		ld2      = v1_q && (!v2_q || ld3);
		in_ready = !v1_q || ld2;
		ld1      = in_valid && in_ready;
	end

	always_comb begin
		flip_next = flip_q;
		if (mode_q == FOLLOW_MODE && tilt_code != TILT_FLAT) begin
			flip_next = (tilt_code == TILT_LEFT);
		end
	end

	assign ctrl = '{ld1: ld1, ld2: ld2, primed: primed_q, slot: slot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= '0;
			mode_q   <= '0;
			primed_q <= 1'b0;
			slot_q   <= '0;
			flip_q   <= 1'b0;
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SENS:   sens_q <= cfg_data;
					REG_ORIENT: mode_q <= cfg_data[1:0];
					default:    sens_q <= sens_q;
				endcase
			end
			if (ld1) begin
				primed_q <= 1'b1;
				flip_q   <= flip_next;
				if (!primed_q || slot_q == SLOT_W'(FILTER_DEPTH - 1)) begin
					slot_q <= (!primed_q) ? SLOT_W'(1) : '0;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
			if (ld1) begin
				v1_q <= 1'b1;
			end else if (ld2) begin
				v1_q <= 1'b0;
			end
			if (ld2) begin
				v2_q <= 1'b1;
			end else if (ld3) begin
				v2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			tick_s1 <= tick_now;
			flip_s1 <= flip_next;
		end
		if (ld2) begin
			tick_s2 <= tick_s1;
			flip_s2 <= flip_s1;
		end
	end

	amd_lane u_lane_x (.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(accel_x), .err_s2(err_x));
	amd_lane u_lane_y (.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(accel_y), .err_s2(err_y));
	amd_lane u_lane_z (.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .sample(accel_z), .err_s2(err_z));

	amd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ld3           (ld3),
		.out_ready     (out_ready),
		.err_x         (err_x),
		.err_y         (err_y),
		.err_z         (err_z),
		.sensitivity   (sens_q),
		.tick_s2       (tick_s2),
		.flip_s2       (flip_s2),
		.out_valid     (out_valid),
		.moved         (moved),
		.motion_error  (motion_error),
		.last_move_tick(last_move_tick),
		.flip_display  (flip_display)
	);

	`AMD_ASSERT_NOW(a_empty_front_ready, !v1_q, in_ready, "empty first stage refused a request")
	`AMD_ASSERT_NEXT(a_primed_after_accept, ld1, primed_q, "ring not primed after a request")
	`AMD_ASSERT_NEXT(a_slot_wraps, ld1 && primed_q && slot_q == SLOT_W'(FILTER_DEPTH - 1),
		slot_q == '0, "write slot failed to wrap")

endmodule

FILE: sim/amd_motion_checker.sv
`timescale 1ns / 100ps

module amd_motion_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_idx,
	input  logic [amd_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic signed [amd_pkg::SAMPLE_W-1:0] accel_x,
	input  logic signed [amd_pkg::SAMPLE_W-1:0] accel_y,
	input  logic signed [amd_pkg::SAMPLE_W-1:0] accel_z,
	input  logic [1:0]                          tilt_code,
	input  logic [amd_pkg::TICK_W-1:0]          tick_now,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                moved,
	input  logic [amd_pkg::MERR_W-1:0]          motion_error,
	input  logic [amd_pkg::TICK_W-1:0]          last_move_tick,
	input  logic                                flip_display,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  results_seen,
	output int                                  moves_seen
);

	typedef struct packed {
		logic                         moved;
		logic [amd_pkg::MERR_W-1:0]   err;
		logic [amd_pkg::TICK_W-1:0]   tick;
		logic                         flip;
	} motion_verdict_t;

	motion_verdict_t awaited_q[$];
	motion_verdict_t want;

	// Shadow of the detector: sample windows, running sums and latched state.
	logic signed [amd_pkg::SAMPLE_W-1:0] window [3][amd_pkg::FILTER_DEPTH];
	int                                  axis_sum [3];
	logic [amd_pkg::SLOT_W-1:0]          slot;
	bit                                  primed;
	logic [amd_pkg::TICK_W-1:0]          move_tick;
	logic                                flip;
	logic [amd_pkg::CFG_W-1:0]           sens;
	logic [1:0]                          orient;
	int                                  fails = 0;
	int                                  checked = 0;
	int                                  moves = 0;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (fails < 40)
			$display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
				$realtime, what, got, exp_val, checked);
		fails++;
	endtask

	function automatic motion_verdict_t predict_motion(input logic signed [15:0] sx,
			input logic signed [15:0] sy, input logic signed [15:0] sz,
			input logic [1:0] tilt, input logic [amd_pkg::TICK_W-1:0] tick);
		int              s [3];
		int              err;
		int              avg;
		int              step;
		int              thr;
		int              a;
		int              i;
		motion_verdict_t v;
		s[0] = sx;
		s[1] = sy;
		s[2] = sz;
		if (orient == amd_pkg::FOLLOW_MODE && tilt != amd_pkg::TILT_FLAT)
			flip = (tilt == amd_pkg::TILT_LEFT);
		err = 0;
		for (a = 0; a < 3; a++) begin
			// The very first request after reset floods the whole window.
			if (!primed) begin
				for (i = 0; i < amd_pkg::FILTER_DEPTH; i++)
					window[a][i] = amd_pkg::SAMPLE_W'(s[a]);
				axis_sum[a] = s[a] * amd_pkg::FILTER_DEPTH;
			end else begin
				axis_sum[a] = axis_sum[a] - window[a][slot] + s[a];
				window[a][slot] = amd_pkg::SAMPLE_W'(s[a]);
			end
			// Integer division truncates toward zero, as the block does.
			avg = axis_sum[a] / amd_pkg::FILTER_DEPTH;
			err += (avg > s[a]) ? avg - s[a] : s[a] - avg;
		end
		primed = 1'b1;
		slot = slot + 1'b1;
		step = (sens > amd_pkg::MAX_STEP) ? int'(amd_pkg::MAX_STEP) : int'(sens);
		thr = int'(amd_pkg::TOP_LEVEL) - step * int'(amd_pkg::STEP_SIZE);
		v.moved = (err > thr);
		if (v.moved)
			move_tick = tick;
		v.err = err[amd_pkg::MERR_W-1:0];
		v.tick = move_tick;
		v.flip = flip;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_q.delete();
			for (int a = 0; a < 3; a++) begin
				axis_sum[a] = 0;
				for (int i = 0; i < amd_pkg::FILTER_DEPTH; i++)
					window[a][i] = '0;
			end
			slot = '0;
			primed = 1'b0;
			move_tick = '0;
			flip = 1'b0;
			sens = '0;
			orient = '0;
			fail_count <= fails;
			pending <= 0;
			results_seen <= 0;
			moves_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == amd_pkg::REG_SENS)
					sens = cfg_data;
				else
					orient = cfg_data[1:0];
			end
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					flag_mismatch("result with no request waiting", motion_error, 0);
				end else begin
					want = awaited_q.pop_front();
					checked++;
					if (moved === 1'b1)
						moves++;
					if (moved !== want.moved)
						flag_mismatch("moved", moved, want.moved);
					if (motion_error !== want.err)
						flag_mismatch("motion_error", motion_error, want.err);
					if (last_move_tick !== want.tick)
						flag_mismatch("last_move_tick", last_move_tick, want.tick);
					if (flip_display !== want.flip)
						flag_mismatch("flip_display", flip_display, want.flip);
				end
			end
			if (in_valid && in_ready)
				awaited_q.push_back(predict_motion(accel_x, accel_y, accel_z,
					tilt_code, tick_now));
			fail_count <= fails;
			pending <= awaited_q.size();
			results_seen <= checked;
			moves_seen <= moves;
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam logic [1:0] TILT_RIGHT = 2'd1;
	localparam logic [1:0] TILT_ODD   = 2'd3;
	localparam logic [1:0] MODE_FIXED = 2'd0;
	localparam logic [1:0] MODE_HOLD  = 2'd1;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [3:0] SENS_OVER  = 4'd15;
	localparam int         CHUNKS      = 15;
	localparam int         CHUNK_LEN   = 100;
	localparam int         DRAIN       = 12;
	localparam int         CYCLE_LIMIT = 400000;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic                                cfg_idx = 1'b0;
	logic [amd_pkg::CFG_W-1:0]           cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic signed [amd_pkg::SAMPLE_W-1:0] accel_x = '0;
	logic signed [amd_pkg::SAMPLE_W-1:0] accel_y = '0;
	logic signed [amd_pkg::SAMPLE_W-1:0] accel_z = '0;
	logic [1:0]                          tilt_code = '0;
	logic [amd_pkg::TICK_W-1:0]          tick_now = '0;
	logic                                out_ready = 1'b0;
	logic                                in_ready;
	logic                                out_valid;
	logic                                moved;
	logic [amd_pkg::MERR_W-1:0]          motion_error;
	logic [amd_pkg::TICK_W-1:0]          last_move_tick;
	logic                                flip_display;

	int                                  fail_count;
	int                                  pending;
	int                                  results_seen;
	int                                  moves_seen;
	int                                  send_idle = 0;
	int                                  recv_idle = 0;
	int                                  hold_left = 0;
	int                                  cycles = 0;
	int                                  sent = 0;
	int                                  reg_writes = 0;
	int                                  base [3];
	int                                  wobble = 8;
	logic [amd_pkg::TICK_W-1:0]          tick_ctr = '0;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	accel_motion_detector u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.tilt_code      (tilt_code),
		.tick_now       (tick_now),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.moved          (moved),
		.motion_error   (motion_error),
		.last_move_tick (last_move_tick),
		.flip_display   (flip_display)
	);

	amd_motion_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.tilt_code      (tilt_code),
		.tick_now       (tick_now),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.moved          (moved),
		.motion_error   (motion_error),
		.last_move_tick (last_move_tick),
		.flip_display   (flip_display),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.moves_seen     (moves_seen)
	);

	// A hold-off, once requested, keeps the output stalled for its whole count.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic offer(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z, input logic [1:0] tilt,
			input logic [amd_pkg::TICK_W-1:0] tick);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		tilt_code <= tilt;
		tick_now <= tick;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// Waits until every request has its result, then lets the pipeline go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [amd_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Mostly a steady attitude with noise around it; now and then a raw sample.
	task automatic offer_wobble();
		logic signed [15:0] v [3];
		int                 a;
		if ($urandom_range(19) == 0)
			tick_ctr = $urandom;
		else
			tick_ctr = tick_ctr + $urandom_range(1, 40);
		if ($urandom_range(99) < 8) begin
			for (a = 0; a < 3; a++)
				v[a] = 16'($urandom);
		end else begin
			for (a = 0; a < 3; a++)
				v[a] = clamp16(base[a] + int'($urandom_range(2 * wobble)) - wobble);
		end
		offer(v[0], v[1], v[2], 2'($urandom_range(3)), tick_ctr);
	endtask

	task automatic pick_attitude();
		int a;
		for (a = 0; a < 3; a++)
			base[a] = int'($urandom_range(65535)) - 32768;
		case ($urandom_range(4))
			0: wobble = 8;
			1: wobble = 300;
			2: wobble = 700;
			3: wobble = 1200;
			default: wobble = 2500;
		endcase
	endtask

	initial begin
		int chunk;
		int k;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Priming request: fills every window slot, so no error can arise.
		offer(16'sh7fff, 16'sh8000, 16'sh0000, amd_pkg::TILT_LEFT, 32'd0);
		settle();
		write_reg(amd_pkg::REG_SENS, SENS_OVER);
		write_reg(amd_pkg::REG_ORIENT, {2'b00, amd_pkg::FOLLOW_MODE});
		// A large step at tick zero latches zero; flat holds, the odd code clears.
		offer(16'sh0000, 16'sh0000, 16'sh0000, amd_pkg::TILT_LEFT, 32'd0);
		offer(16'sh0000, 16'sh0000, 16'sh0000, amd_pkg::TILT_FLAT, 32'd5);
		offer(16'sh0000, 16'sh0000, 16'sh0000, TILT_ODD, 32'd6);
		offer(-16'sd1, -16'sd1, -16'sd1, TILT_RIGHT, 32'hffff_ffff);
		offer(16'sh8000, 16'sh8000, 16'sh8000, amd_pkg::TILT_LEFT, 32'd7);
		offer(16'sh7fff, 16'sh7fff, 16'sh7fff, amd_pkg::TILT_LEFT, 32'd8);
		settle();
		write_reg(amd_pkg::REG_SENS, amd_pkg::MAX_STEP);
		write_reg(amd_pkg::REG_ORIENT, {2'b00, MODE_HOLD});
		offer(16'sd100, -16'sd100, 16'sd7, TILT_RIGHT, 32'd9);
		offer(-16'sd7, 16'sd3, -16'sd9, amd_pkg::TILT_LEFT, 32'd10);
		settle();
		write_reg(amd_pkg::REG_SENS, 4'd0);
		write_reg(amd_pkg::REG_ORIENT, {2'b00, MODE_SPARE});
		offer(16'sh0000, 16'sh0000, 16'sh0000, amd_pkg::TILT_LEFT, 32'd11);
		offer(16'sd1500, 16'sh0000, 16'sh0000, amd_pkg::TILT_FLAT, 32'd12);
		settle();
		write_reg(amd_pkg::REG_ORIENT, {2'b00, MODE_FIXED});
		offer(-16'sd5, -16'sd5, -16'sd5, TILT_RIGHT, 32'd13);

		tick_ctr = 32'd100;
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			send_idle = (chunk < 5) ? 13 : (chunk < 10) ? 63 : 0;
			recv_idle = (chunk < 5) ? 63 : (chunk < 10) ? 13 : 0;
			settle();
			write_reg(amd_pkg::REG_SENS, 4'($urandom_range(15)));
			write_reg(amd_pkg::REG_ORIENT, {2'b00, 2'($urandom_range(3))});
			for (k = 0; k < CHUNK_LEN; k++) begin
				if (k % 25 == 0)
					pick_attitude();
				// The sender keeps offering while the output is stalled for long.
				if (chunk == 11 && k == 20)
					hold_left = 80;
				offer_wobble();
			end
		end
		settle();

		$display("Run covered %0d requests and %0d checked results, %0d flagged as movement.",
			sent, results_seen, moves_seen);
		$display("Registers written %0d times; idle mixes 13/63, 63/13 and none, one long stall.",
			reg_writes);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
